FILE: design/rqrmc_pkg.sv
// shared types and constants for the rain-qualified roof motor controller
`timescale 1ns / 1ps

package rqrmc_pkg;

  // default counter width for the run and move timers
  localparam int unsigned TIMER_BITS_DEF = 17;

  localparam int unsigned THR_W  = 16;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DATA_W = 16;

  // register reset values
  localparam logic [THR_W-1:0]  RAIN_CONFIRM_RST = 16'd3000;
  localparam logic [THR_W-1:0]  DRY_CONFIRM_RST  = 16'd30000;
  localparam logic [THR_W-1:0]  MAX_MOVE_RST     = 16'd8000;
  localparam logic [DUTY_W-1:0] DRIVE_DUTY_RST   = 8'd200;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_RAIN_CONFIRM = 2'd0,
    CFG_DRY_CONFIRM  = 2'd1,
    CFG_MAX_MOVE     = 2'd2,
    CFG_DRIVE_DUTY   = 2'd3
  } cfg_idx_t;

  // roof position / motion
  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_CLOSED  = 2'd1,
    MODE_CLOSING = 2'd2,
    MODE_OPENING = 2'd3
  } roof_mode_t;

  typedef struct packed {
    logic [THR_W-1:0]  rain_confirm_ticks;
    logic [THR_W-1:0]  dry_confirm_ticks;
    logic [THR_W-1:0]  max_move_ticks;
    logic [DUTY_W-1:0] drive_duty;
  } cfg_t;

  typedef struct packed {
    roof_mode_t        mode;
    logic              bridge_a;
    logic              bridge_b;
    logic [DUTY_W-1:0] pwm_duty;
    logic              move_timeout;
  } result_t;

endpackage

FILE: design/rqrmc_cfg.sv
// configuration register bank
`timescale 1ns / 1ps

module rqrmc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rqrmc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [rqrmc_pkg::DATA_W-1:0]     cfg_data,
  output rqrmc_pkg::cfg_t                  cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rain_confirm_ticks <= rqrmc_pkg::RAIN_CONFIRM_RST;
      cfg.dry_confirm_ticks  <= rqrmc_pkg::DRY_CONFIRM_RST;
      cfg.max_move_ticks     <= rqrmc_pkg::MAX_MOVE_RST;
      cfg.drive_duty         <= rqrmc_pkg::DRIVE_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rqrmc_pkg::CFG_RAIN_CONFIRM: cfg.rain_confirm_ticks <= cfg_data;
        rqrmc_pkg::CFG_DRY_CONFIRM:  cfg.dry_confirm_ticks  <= cfg_data;
        rqrmc_pkg::CFG_MAX_MOVE:     cfg.max_move_ticks     <= cfg_data;
        rqrmc_pkg::CFG_DRIVE_DUTY:
          cfg.drive_duty <= cfg_data[rqrmc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/rqrmc_step.sv
// per-tick next-state and motor drive logic
`timescale 1ns / 1ps

module rqrmc_step #(
  parameter int unsigned TIMER_BITS = rqrmc_pkg::TIMER_BITS_DEF
) (
  input  rqrmc_pkg::cfg_t        cfg,
  input  logic                   wet,
  input  logic                   open_hit,
  input  logic                   close_hit,
  input  rqrmc_pkg::roof_mode_t  mode,
  input  logic                   run_is_wet,
  input  logic                   run_valid,
  input  logic [TIMER_BITS-1:0]  run_ticks,
  input  logic [TIMER_BITS-1:0]  move_ticks,
  output rqrmc_pkg::roof_mode_t  mode_next,
  output logic                   run_is_wet_next,
  output logic                   run_valid_next,
  output logic [TIMER_BITS-1:0]  run_ticks_next,
  output logic [TIMER_BITS-1:0]  move_ticks_next,
  output rqrmc_pkg::result_t     res
);

  // compare width covers both the counters and the 16-bit thresholds
  localparam int unsigned CW = (TIMER_BITS > rqrmc_pkg::THR_W) ? TIMER_BITS
                                                                : rqrmc_pkg::THR_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic                  new_run;
  logic [TIMER_BITS-1:0] run_inc;
  logic [TIMER_BITS-1:0] move_inc;
  logic                  rain_ok;
  logic                  dry_ok;

  // run length tracking with saturation
  assign new_run         = !run_valid || (run_is_wet != wet);
  assign run_inc         = (run_ticks == TMAX) ? TMAX : run_ticks + 1'b1;
  assign move_inc        = (move_ticks == TMAX) ? TMAX : move_ticks + 1'b1;
  assign run_valid_next  = 1'b1;
  assign run_is_wet_next = wet;
  assign run_ticks_next  = new_run ? '0 : run_inc;

  // confirmation on the updated run length
  assign rain_ok = wet && (CW'(run_ticks_next) > CW'(cfg.rain_confirm_ticks));
  assign dry_ok  = !wet && (CW'(run_ticks_next) > CW'(cfg.dry_confirm_ticks));

  // mode transitions and bridge drive
  always_comb begin
    rqrmc_pkg::roof_mode_t m;
    logic [TIMER_BITS-1:0] mv;
    logic                  opening;
    logic                  hit;
    m       = mode;
    mv      = move_inc;
    res     = '0;
    if (rain_ok && m != rqrmc_pkg::MODE_CLOSED && m != rqrmc_pkg::MODE_CLOSING) begin
      m  = rqrmc_pkg::MODE_CLOSING;
      mv = '0;
    end
    if (dry_ok && m != rqrmc_pkg::MODE_OPEN && m != rqrmc_pkg::MODE_OPENING) begin
      m  = rqrmc_pkg::MODE_OPENING;
      mv = '0;
    end
    opening = (m == rqrmc_pkg::MODE_OPENING);
    hit     = opening ? open_hit : close_hit;
    if (m == rqrmc_pkg::MODE_CLOSING || m == rqrmc_pkg::MODE_OPENING) begin
      if (hit) begin
        m = opening ? rqrmc_pkg::MODE_OPEN : rqrmc_pkg::MODE_CLOSED;
      end else if (CW'(mv) > CW'(cfg.max_move_ticks)) begin
        res.move_timeout = 1'b1;
      end else begin
        res.bridge_a = opening;
        res.bridge_b = !opening;
        res.pwm_duty = cfg.drive_duty;
      end
    end
    res.mode        = m;
    mode_next       = m;
    move_ticks_next = mv;
  end

endmodule

FILE: design/rain_qualified_roof_motor_controller.sv
// A tick accepted into the input register is evaluated into the result register, which drives the result port.
// Throughput: one tick per cycle; the input register and the result register each
// advance whenever the result register is empty or its transfer completes.
// Reset (rst, synchronous): roof open, no run, timers zero, registers at defaults,
// both pipeline stages empty.
`timescale 1ns / 1ps

module rain_qualified_roof_motor_controller #(
  parameter int unsigned TIMER_BITS = rqrmc_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               rain_wet,
  input  logic                               open_limit_hit,
  input  logic                               close_limit_hit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         roof_mode,
  output logic                               bridge_a,
  output logic                               bridge_b,
  output logic [rqrmc_pkg::DUTY_W-1:0]       pwm_duty,
  output logic                               move_timeout,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rqrmc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rqrmc_pkg::DATA_W-1:0]       cfg_data
);

  rqrmc_pkg::cfg_t       cfg;

  logic                  in_q_valid;
  logic                  in_q_wet;
  logic                  in_q_open;
  logic                  in_q_close;
  logic                  advance;
  logic                  in_take;

  rqrmc_pkg::roof_mode_t mode;
  rqrmc_pkg::roof_mode_t mode_next;
  logic                  run_is_wet;
  logic                  run_is_wet_next;
  logic                  run_valid;
  logic                  run_valid_next;
  logic [TIMER_BITS-1:0] run_ticks;
  logic [TIMER_BITS-1:0] run_ticks_next;
  logic [TIMER_BITS-1:0] move_ticks;
  logic [TIMER_BITS-1:0] move_ticks_next;
  rqrmc_pkg::result_t    res_next;
  rqrmc_pkg::result_t    res;

  // configuration registers
  rqrmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_wet   <= rain_wet;
      in_q_open  <= open_limit_hit;
      in_q_close <= close_limit_hit;
    end
  end

  // tick evaluation
  rqrmc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg             (cfg),
    .wet             (in_q_wet),
    .open_hit        (in_q_open),
    .close_hit       (in_q_close),
    .mode            (mode),
    .run_is_wet      (run_is_wet),
    .run_valid       (run_valid),
    .run_ticks       (run_ticks),
    .move_ticks      (move_ticks),
    .mode_next       (mode_next),
    .run_is_wet_next (run_is_wet_next),
    .run_valid_next  (run_valid_next),
    .run_ticks_next  (run_ticks_next),
    .move_ticks_next (move_ticks_next),
    .res             (res_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= rqrmc_pkg::MODE_OPEN;
      run_is_wet <= 1'b0;
      run_valid  <= 1'b0;
      run_ticks  <= '0;
      move_ticks <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      run_is_wet <= run_is_wet_next;
      run_valid  <= run_valid_next;
      run_ticks  <= run_ticks_next;
      move_ticks <= move_ticks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign roof_mode    = res.mode;
  assign bridge_a     = res.bridge_a;
  assign bridge_b     = res.bridge_b;
  assign pwm_duty     = res.pwm_duty;
  assign move_timeout = res.move_timeout;

`ifndef SYNTH
  // a settled roof never drives the motor
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (roof_mode == rqrmc_pkg::MODE_OPEN || roof_mode == rqrmc_pkg::MODE_CLOSED)
    |-> !bridge_a && !bridge_b && pwm_duty == '0 && !move_timeout)
    else $error("settled roof with motor drive or timeout");

  // a timed-out move holds the motor off
  assert property (@(posedge clk) disable iff (rst)
    out_valid && move_timeout |-> !bridge_a && !bridge_b && pwm_duty == '0)
    else $error("motor driven during timeout");

  // the bridge is never driven both ways
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bridge_a && bridge_b))
    else $error("both bridge inputs high");

  // a stalled result keeps the tick in the input register
  assert property (@(posedge clk) disable iff (rst)
    in_q_valid && out_valid && out_stall |=> in_q_valid && $stable(mode))
    else $error("tick lost or state changed under stall");
`endif

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the rain-qualified roof motor controller
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TICK_W = rqrmc_pkg::TIMER_BITS_DEF;

  typedef logic [TICK_W-1:0] tick_t;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic rain_wet = 1'b0;
  logic open_limit_hit = 1'b0;
  logic close_limit_hit = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] roof_mode;
  logic bridge_a;
  logic bridge_b;
  logic [rqrmc_pkg::DUTY_W-1:0] pwm_duty;
  logic move_timeout;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  rqrmc_pkg::cfg_idx_t cfg_index = rqrmc_pkg::CFG_RAIN_CONFIRM;
  logic [rqrmc_pkg::DATA_W-1:0] cfg_data = '0;

  // shadow of the roof controller state and its registers
  rqrmc_pkg::roof_mode_t roof_state = rqrmc_pkg::MODE_OPEN;
  logic run_wet = 1'b0;
  logic run_started = 1'b0;
  tick_t run_count = '0;
  tick_t move_count = '0;
  rqrmc_pkg::cfg_t roof_cfg = '{rqrmc_pkg::RAIN_CONFIRM_RST, rqrmc_pkg::DRY_CONFIRM_RST,
                                rqrmc_pkg::MAX_MOVE_RST, rqrmc_pkg::DRIVE_DUTY_RST};

  // outputs still owed by the block, oldest first
  rqrmc_pkg::result_t pending_outputs[$];
  int fail_count = 0;

  // sender burst control
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver stall pattern
  int rx_style = 0;
  int rx_left = 0;
  int rx_count = 0;

  always #4 clk = ~clk;

  rain_qualified_roof_motor_controller #(
    .TIMER_BITS(TICK_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rain_wet(rain_wet),
    .open_limit_hit(open_limit_hit),
    .close_limit_hit(close_limit_hit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .roof_mode(roof_mode),
    .bridge_a(bridge_a),
    .bridge_b(bridge_b),
    .pwm_duty(pwm_duty),
    .move_timeout(move_timeout),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // saturating timer step
  function automatic tick_t tick_up(input tick_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // advance the shadow state by one tick and return the motor outputs it gives
  function automatic rqrmc_pkg::result_t next_roof_output(input logic wet,
                                                          input logic open_hit,
                                                          input logic close_hit);
    rqrmc_pkg::result_t r;
    logic rain_ok;
    logic dry_ok;
    logic hit;
    r = '0;
    if (!run_started || run_wet != wet) begin
      run_started = 1'b1;
      run_wet = wet;
      run_count = '0;
    end else begin
      run_count = tick_up(run_count);
    end
    rain_ok = wet && (run_count > roof_cfg.rain_confirm_ticks);
    dry_ok = !wet && (run_count > roof_cfg.dry_confirm_ticks);
    move_count = tick_up(move_count);

    // a confirmation that disagrees with the roof starts a move
    if (rain_ok && roof_state != rqrmc_pkg::MODE_CLOSED &&
        roof_state != rqrmc_pkg::MODE_CLOSING) begin
      roof_state = rqrmc_pkg::MODE_CLOSING;
      move_count = '0;
    end
    if (dry_ok && roof_state != rqrmc_pkg::MODE_OPEN &&
        roof_state != rqrmc_pkg::MODE_OPENING) begin
      roof_state = rqrmc_pkg::MODE_OPENING;
      move_count = '0;
    end

    // moving: matching switch settles, else timeout or drive
    if (roof_state == rqrmc_pkg::MODE_CLOSING || roof_state == rqrmc_pkg::MODE_OPENING) begin
      hit = (roof_state == rqrmc_pkg::MODE_OPENING) ? open_hit : close_hit;
      if (hit) begin
        roof_state = (roof_state == rqrmc_pkg::MODE_OPENING) ? rqrmc_pkg::MODE_OPEN
                                                             : rqrmc_pkg::MODE_CLOSED;
      end else if (move_count > roof_cfg.max_move_ticks) begin
        r.move_timeout = 1'b1;
      end else begin
        r.bridge_a = (roof_state == rqrmc_pkg::MODE_OPENING);
        r.bridge_b = (roof_state == rqrmc_pkg::MODE_CLOSING);
        r.pwm_duty = roof_cfg.drive_duty;
      end
    end
    r.mode = roof_state;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin
    rqrmc_pkg::result_t got;
    rqrmc_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.mode = rqrmc_pkg::roof_mode_t'(roof_mode);
      got.bridge_a = bridge_a;
      got.bridge_b = bridge_b;
      got.pwm_duty = pwm_duty;
      got.move_timeout = move_timeout;
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("result with nothing expected: mode=%0d a=%0b b=%0b duty=%0d to=%0b",
                               got.mode, got.bridge_a, got.bridge_b, got.pwm_duty,
                               got.move_timeout));
      end else begin
        want = pending_outputs.pop_front();
        if (got.mode !== want.mode || got.bridge_a !== want.bridge_a ||
            got.bridge_b !== want.bridge_b || got.pwm_duty !== want.pwm_duty ||
            got.move_timeout !== want.move_timeout) begin
          note_failure($sformatf(
            "mismatch exp mode=%0d a=%0b b=%0b duty=%0d to=%0b, got mode=%0d a=%0b b=%0b duty=%0d to=%0b",
            want.mode, want.bridge_a, want.bridge_b, want.pwm_duty, want.move_timeout,
            got.mode, got.bridge_a, got.bridge_b, got.pwm_duty, got.move_timeout));
        end
      end
    end

    // pick a new stall style every so often
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_count++;
    case (rx_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ((rx_count % 7) < 3);
    endcase
  end

  // one tick transfer, with random gaps between bursts
  task automatic send_tick(input logic wet, input logic open_hit, input logic close_hit);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    rain_wet <= wet;
    open_limit_hit <= open_hit;
    close_limit_hit <= close_hit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outputs.push_back(next_roof_output(wet, open_hit, close_hit));
    burst_left--;
  endtask

  task automatic hold_ticks(input int n, input logic wet, input logic open_hit,
                            input logic close_hit);
    repeat (n) send_tick(wet, open_hit, close_hit);
  endtask

  // stop sending and wait until every owed result has arrived
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rqrmc_pkg::cfg_idx_t idx,
                           input logic [rqrmc_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rqrmc_pkg::CFG_RAIN_CONFIRM: roof_cfg.rain_confirm_ticks = data;
      rqrmc_pkg::CFG_DRY_CONFIRM: roof_cfg.dry_confirm_ticks = data;
      rqrmc_pkg::CFG_MAX_MOVE: roof_cfg.max_move_ticks = data;
      rqrmc_pkg::CFG_DRIVE_DUTY: roof_cfg.drive_duty = data[rqrmc_pkg::DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // write all four registers back to back, block must be idle
  task automatic apply_config(input logic [rqrmc_pkg::DATA_W-1:0] rain_thr,
                              input logic [rqrmc_pkg::DATA_W-1:0] dry_thr,
                              input logic [rqrmc_pkg::DATA_W-1:0] move_max,
                              input logic [rqrmc_pkg::DATA_W-1:0] duty);
    write_reg(rqrmc_pkg::CFG_RAIN_CONFIRM, rain_thr);
    write_reg(rqrmc_pkg::CFG_DRY_CONFIRM, dry_thr);
    write_reg(rqrmc_pkg::CFG_MAX_MOVE, move_max);
    write_reg(rqrmc_pkg::CFG_DRIVE_DUTY, duty);
    cfg_valid <= 1'b0;
  endtask

  // reset values: short wet and dry runs confirm nothing, roof stays open
  task automatic test_default_settings();
    hold_ticks(40, 1'b1, 1'b0, 1'b0);
    hold_ticks(40, 1'b0, 1'b1, 1'b0);
  endtask

  // short thresholds: close on rain, open on dryness, time out, settle
  task automatic test_move_cycle();
    drain_outputs();
    apply_config(16'd20, 16'd30, 16'd40, 16'd200);
    send_tick(1'b1, 1'b1, 1'b0);
    hold_ticks(20, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    // wrong switch while closing is ignored
    hold_ticks(5, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    hold_ticks(3, 1'b1, 1'b1, 1'b1);
    hold_ticks(32, 1'b0, 1'b0, 1'b0);
    // opening until the move limit passes, then stuck
    hold_ticks(44, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // zero thresholds, timeout right after start, reversal, both switches
  task automatic test_edge_cases();
    drain_outputs();
    apply_config('0, '0, '0, 16'h00FF);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    drain_outputs();
    // zero duty, no timeout, rain while opening reverses
    apply_config('0, '0, 16'hFFFF, 16'hFF00);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
  endtask

  // largest thresholds: a long unbroken run confirms nothing and no move times out
  task automatic test_extreme_settings();
    drain_outputs();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gaps_on = 1'b0;
    hold_ticks(150, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    gaps_on = 1'b1;
  endtask

  function automatic logic [rqrmc_pkg::DATA_W-1:0] pick_limit(input int upper);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rqrmc_pkg::DATA_W'($urandom_range(0, upper));
    endcase
  endfunction

  // weather runs around the thresholds, switches that follow the motion
  task automatic test_random_phases(input int phases, input int per_phase);
    int sent;
    int span;
    int run_len;
    int hit_odds;
    logic wet;
    logic open_hit;
    logic close_hit;
    repeat (phases) begin
      drain_outputs();
      apply_config(pick_limit(40), pick_limit(40), pick_limit(60),
                   rqrmc_pkg::DATA_W'($urandom_range(0, 65535)));
      hit_odds = $urandom_range(2, 60);
      sent = 0;
      while (sent < per_phase) begin
        wet = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
          run_len = $urandom_range(1, 3);
        end else begin
          span = wet ? int'(roof_cfg.rain_confirm_ticks) : int'(roof_cfg.dry_confirm_ticks);
          if (span > 60) span = 60;
          run_len = $urandom_range(1, span + 8);
        end
        repeat (run_len) begin
          open_hit = ($urandom_range(0, 19) == 0);
          close_hit = ($urandom_range(0, 19) == 0);
          if (roof_state == rqrmc_pkg::MODE_OPENING) open_hit = ($urandom_range(1, hit_odds) == 1);
          if (roof_state == rqrmc_pkg::MODE_CLOSING) close_hit = ($urandom_range(1, hit_odds) == 1);
          send_tick(wet, open_hit, close_hit);
          sent++;
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_settings();
    test_move_cycle();
    test_edge_cases();
    test_extreme_settings();
    test_random_phases(6, 130);
    drain_outputs();
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
